>>> rtl/pidr_pkg.sv
// Shared types, constants, microcode table and saturation helper for the PID controller.
`default_nettype none

package pidr_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int EXT_W   = PROD_W - FRAC_W;
    localparam int ACC_W   = DATA_W + 2;
    localparam int DRIVE_W = FRAC_W + 1;
    localparam int UNS_W   = DATA_W - 1;
    localparam int PC_W    = 4;
    localparam int ADDR_W  = 5;
    localparam int TDATA_OUT_W = 24;

    localparam logic signed [EXT_W-1:0] DMAX_EXT =
        {{(EXT_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] DMIN_EXT =
        {{(EXT_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1 << (FRAC_W - 1));

    // register indexes
    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_ACCEL  = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_KP     = 3'd3;
    localparam logic [2:0] REG_KI     = 3'd4;
    localparam logic [2:0] REG_KD     = 3'd5;
    localparam logic [2:0] REG_KFF    = 3'd6;
    localparam logic [2:0] REG_ILIM   = 3'd7;

    localparam logic [UNS_W-1:0] PERIOD_RESET = UNS_W'(655);
    localparam logic [UNS_W-1:0] ILIM_RESET   = {UNS_W{1'b1}};

    // microcode addresses
    localparam logic [PC_W-1:0] PC_SETPOINT = 4'd0;
    localparam logic [PC_W-1:0] PC_ERROR    = 4'd1;
    localparam logic [PC_W-1:0] PC_DERIV    = 4'd2;
    localparam logic [PC_W-1:0] PC_INTEG    = 4'd3;
    localparam logic [PC_W-1:0] PC_TERM_P   = 4'd4;
    localparam logic [PC_W-1:0] PC_TERM_I   = 4'd5;
    localparam logic [PC_W-1:0] PC_TERM_FF  = 4'd6;
    localparam logic [PC_W-1:0] PC_OUTPUT   = 4'd7;
    localparam logic [PC_W-1:0] PC_CLEAR    = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_SETPOINT  = 4'd1,
        OP_ERROR     = 4'd2,
        OP_DERIV     = 4'd3,
        OP_INTEG     = 4'd4,
        OP_ACC_LOAD  = 4'd5,
        OP_ACC_ADD   = 4'd6,
        OP_OUTPUT    = 4'd7,
        OP_CLR_INTEG = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_ERR_DT = 3'd1,
        MUL_KP_ERR = 3'd2,
        MUL_KI_INT = 3'd3,
        MUL_KFF_SP = 3'd4,
        MUL_KD_DER = 3'd5
    } mul_t;

    typedef enum logic {
        BR_NONE   = 1'b0,
        BR_ACTION = 1'b1
    } br_t;

    typedef struct packed {
        op_t             op;
        mul_t            mul;
        br_t             br;
        logic [PC_W-1:0] target;
        logic            last;
        logic            emit;
    } uword_t;

    typedef struct packed {
        logic load;
        op_t  op;
        mul_t mul;
    } ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic [UNS_W-1:0]         accel;
        logic [UNS_W-1:0]         period;
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic signed [DATA_W-1:0] kd;
        logic signed [DATA_W-1:0] kff;
        logic [UNS_W-1:0]         ilim;
    } cfg_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [EXT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > DMAX_EXT)
        begin
            r = DMAX_EXT[DATA_W-1:0];
        end
        else if (v < DMIN_EXT)
        begin
            r = DMIN_EXT[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w.op     = OP_NONE;
        w.mul    = MUL_NONE;
        w.br     = BR_NONE;
        w.target = PC_SETPOINT;
        w.last   = 1'b0;
        w.emit   = 1'b0;
        unique case (pc)
            PC_SETPOINT:
            begin
                // zero-integrator items branch off before touching state
                w.op     = OP_SETPOINT;
                w.br     = BR_ACTION;
                w.target = PC_CLEAR;
            end
            PC_ERROR:
            begin
                w.op = OP_ERROR;
            end
            PC_DERIV:
            begin
                w.op  = OP_DERIV;
                w.mul = MUL_ERR_DT;
            end
            PC_INTEG:
            begin
                w.op  = OP_INTEG;
                w.mul = MUL_KP_ERR;
            end
            PC_TERM_P:
            begin
                w.op  = OP_ACC_LOAD;
                w.mul = MUL_KI_INT;
            end
            PC_TERM_I:
            begin
                w.op  = OP_ACC_ADD;
                w.mul = MUL_KFF_SP;
            end
            PC_TERM_FF:
            begin
                w.op  = OP_ACC_ADD;
                w.mul = MUL_KD_DER;
            end
            PC_OUTPUT:
            begin
                w.op   = OP_OUTPUT;
                w.last = 1'b1;
                w.emit = 1'b1;
            end
            PC_CLEAR:
            begin
                w.op   = OP_CLR_INTEG;
                w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pidr_regs.sv
// APB configuration register file for the PID controller.
`default_nettype none

module pidr_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pidr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pidr_pkg::cfg_t                  cfg
);
    import pidr_pkg::*;

    logic signed [DATA_W-1:0] target_reg;
    logic [UNS_W-1:0]         accel_reg;
    logic [UNS_W-1:0]         period_reg;
    logic signed [DATA_W-1:0] kp_reg;
    logic signed [DATA_W-1:0] ki_reg;
    logic signed [DATA_W-1:0] kd_reg;
    logic signed [DATA_W-1:0] kff_reg;
    logic [UNS_W-1:0]         ilim_reg;
    logic                     wr_en;
    logic [2:0]               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            accel_reg  <= '0;
            period_reg <= PERIOD_RESET;
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            kff_reg    <= '0;
            ilim_reg   <= ILIM_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET: target_reg <= pwdata;
                REG_ACCEL:  accel_reg  <= pwdata[UNS_W-1:0];
                REG_PERIOD: period_reg <= pwdata[UNS_W-1:0];
                REG_KP:     kp_reg     <= pwdata;
                REG_KI:     ki_reg     <= pwdata;
                REG_KD:     kd_reg     <= pwdata;
                REG_KFF:    kff_reg    <= pwdata;
                REG_ILIM:   ilim_reg   <= pwdata[UNS_W-1:0];
                default:    target_reg <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET: prdata = target_reg;
            REG_ACCEL:  prdata = {1'b0, accel_reg};
            REG_PERIOD: prdata = {1'b0, period_reg};
            REG_KP:     prdata = kp_reg;
            REG_KI:     prdata = ki_reg;
            REG_KD:     prdata = kd_reg;
            REG_KFF:    prdata = kff_reg;
            REG_ILIM:   prdata = {1'b0, ilim_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.target = target_reg;
    assign cfg.accel  = accel_reg;
    assign cfg.period = period_reg;
    assign cfg.kp     = kp_reg;
    assign cfg.ki     = ki_reg;
    assign cfg.kd     = kd_reg;
    assign cfg.kff    = kff_reg;
    assign cfg.ilim   = ilim_reg;

endmodule

`default_nettype wire

>>> rtl/pidr_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch on the item kind.
`default_nettype none

module pidr_sequencer (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    input  wire logic      s_tuser,
    output logic           s_tready,
    input  wire logic      out_busy,
    output pidr_pkg::ctl_t ctl
);
    import pidr_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic            action_reg;
    uword_t          word;
    logic            taken;
    logic            stall;
    logic            exec;
    logic            accept;

    assign word  = ucode(pc_reg);
    assign taken = busy_reg && (word.br == BR_ACTION) && action_reg;
    // hold the final step while the previous result is still waiting
    assign stall = busy_reg && word.emit && out_busy;
    assign exec  = busy_reg && !stall && !taken;

    assign s_tready = !busy_reg || (word.last && !stall && !taken);
    assign accept   = s_tvalid && s_tready;

    assign ctl.load = accept;
    assign ctl.op   = exec ? word.op : OP_NONE;
    assign ctl.mul  = exec ? word.mul : MUL_NONE;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            pc_next   = PC_SETPOINT;
            busy_next = 1'b1;
        end
        else if (busy_reg && !stall)
        begin
            if (taken)
            begin
                pc_next = word.target;
            end
            else if (word.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= PC_SETPOINT;
            busy_reg   <= 1'b0;
            action_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            if (accept)
            begin
                action_reg <= s_tuser;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidr_datapath.sv
// Controller datapath: state registers, shared multiplier, accumulator and output register.
`default_nettype none

module pidr_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pidr_pkg::ctl_t                    ctl,
    input  wire pidr_pkg::cfg_t                    cfg,
    input  wire logic [pidr_pkg::DATA_W-1:0]       meas_in,
    output logic [pidr_pkg::TDATA_OUT_W-1:0]       m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   out_busy
);
    import pidr_pkg::*;

    logic signed [DATA_W-1:0]  meas_reg;
    logic signed [DATA_W-1:0]  sp_reg;
    logic signed [DATA_W-1:0]  integ_reg;
    logic signed [DATA_W-1:0]  prev_reg;
    logic signed [DATA_W-1:0]  err_reg;
    logic signed [DATA_W-1:0]  deriv_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      flag_reg;
    logic                      out_valid_reg;

    logic signed [DATA_W-1:0]  term;
    logic signed [DATA_W:0]    sp_diff;
    logic signed [DATA_W:0]    step_pos;
    logic signed [DATA_W:0]    sp_diff_c;
    logic signed [DATA_W-1:0]  sp_new;
    logic signed [DATA_W-1:0]  err_new;
    logic signed [DATA_W-1:0]  deriv_new;
    logic signed [DATA_W-1:0]  integ_sum;
    logic signed [DATA_W-1:0]  lim;
    logic signed [DATA_W-1:0]  integ_new;
    logic                      both_zero;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]   out_sum;
    logic signed [DRIVE_W-1:0] drive_new;
    logic                      flag_new;

    // product scaled back to the fixed-point grid, floor rounding
    assign term = sat_data(prod_reg[PROD_W-1:FRAC_W]);

    // setpoint ramp
    assign sp_diff  = (DATA_W + 1)'(cfg.target) - (DATA_W + 1)'(sp_reg);
    assign step_pos = {2'b00, cfg.accel};
    always_comb
    begin
        if (sp_diff > step_pos)
        begin
            sp_diff_c = step_pos;
        end
        else if (sp_diff < -step_pos)
        begin
            sp_diff_c = -step_pos;
        end
        else
        begin
            sp_diff_c = sp_diff;
        end
        if (cfg.accel == '0)
        begin
            sp_new = cfg.target;
        end
        else
        begin
            sp_new = sat_data(EXT_W'(sp_reg) + EXT_W'(sp_diff_c));
        end
    end

    assign err_new   = sat_data(EXT_W'(sp_reg) - EXT_W'(meas_reg));
    assign deriv_new = sat_data(EXT_W'(err_reg) - EXT_W'(prev_reg));

    // integrator with zero-input clear and magnitude clamp
    assign integ_sum = sat_data(EXT_W'(integ_reg) + EXT_W'(term));
    assign lim       = {1'b0, cfg.ilim};
    assign both_zero = (cfg.target == '0) && (meas_reg == '0);
    always_comb
    begin
        if (both_zero)
        begin
            integ_new = '0;
        end
        else if (integ_sum > lim)
        begin
            integ_new = lim;
        end
        else if (integ_sum < -lim)
        begin
            integ_new = -lim;
        end
        else
        begin
            integ_new = integ_sum;
        end
    end

    always_comb
    begin
        unique case (ctl.mul)
            MUL_ERR_DT:
            begin
                mul_a = err_reg;
                mul_b = {1'b0, cfg.period};
            end
            MUL_KP_ERR:
            begin
                mul_a = cfg.kp;
                mul_b = err_reg;
            end
            MUL_KI_INT:
            begin
                mul_a = cfg.ki;
                mul_b = integ_reg;
            end
            MUL_KFF_SP:
            begin
                mul_a = cfg.kff;
                mul_b = sp_reg;
            end
            MUL_KD_DER:
            begin
                mul_a = cfg.kd;
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = err_reg;
                mul_b = err_reg;
            end
        endcase
    end

    // final sum and drive clamp
    assign out_sum = acc_reg + ACC_W'(term);
    always_comb
    begin
        if (out_sum > HALF_ACC)
        begin
            drive_new = HALF_ACC[DRIVE_W-1:0];
            flag_new  = 1'b1;
        end
        else if (out_sum < -HALF_ACC)
        begin
            drive_new = -HALF_ACC[DRIVE_W-1:0];
            flag_new  = 1'b1;
        end
        else
        begin
            drive_new = out_sum[DRIVE_W-1:0];
            flag_new  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.op == OP_SETPOINT)
            begin
                sp_reg <= sp_new;
            end
            if (ctl.op == OP_DERIV)
            begin
                prev_reg <= err_reg;
            end
            if (ctl.op == OP_INTEG)
            begin
                integ_reg <= integ_new;
            end
            else if (ctl.op == OP_CLR_INTEG)
            begin
                integ_reg <= '0;
            end
            if (ctl.op == OP_OUTPUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            meas_reg <= meas_in;
        end
        if (ctl.op == OP_ERROR)
        begin
            err_reg <= err_new;
        end
        if (ctl.op == OP_DERIV)
        begin
            deriv_reg <= deriv_new;
        end
        if (ctl.mul != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctl.op == OP_ACC_LOAD)
        begin
            acc_reg <= ACC_W'(term);
        end
        else if (ctl.op == OP_ACC_ADD)
        begin
            acc_reg <= out_sum;
        end
        if (ctl.op == OP_OUTPUT)
        begin
            drive_reg <= drive_new;
            flag_reg  <= flag_new;
        end
    end

    assign m_tdata  = {{(TDATA_OUT_W - DRIVE_W){1'b0}}, drive_reg};
    assign m_tuser  = flag_reg;
    assign m_tvalid = out_valid_reg;
    assign out_busy = out_valid_reg && !m_tready;

endmodule

`default_nettype wire

>>> rtl/pid_ramped_setpoint_controller.sv
// Results: a sample transfer yields its result from the output step of its microprogram;
// a zero-integrator transfer branches to the clear step and yields no result.
// The sample microprogram has 8 steps driving one shared 32x32 multiplier; a new
// transfer is taken on the last step unless the previous result is still waiting.
// Reset: rst_n clears the setpoint ramp, integrator, previous error and
// the configuration registers to their defaults; no clearing pass is needed.
`default_nettype none

module pid_ramped_setpoint_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pidr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // [31:0] measured
    input  wire logic                        s_tuser,   // [0] action
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // [16:0] drive, [23:17] zero
    output logic                             m_tuser    // [0] saturated
);
    import pidr_pkg::*;

    cfg_t cfg;
    ctl_t ctl;
    logic out_busy;

    pidr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    pidr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cfg      (cfg),
        .meas_in  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_busy (out_busy)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the ramped-setpoint PID controller with feedforward.
`timescale 1ns / 1ps

module testbench;
    import pidr_pkg::*;

    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;
    localparam int   REG_COUNT   = 8;
    localparam int   CYCLE_LIMIT = 500000;
    localparam int   SETTLE      = 12;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } drive_result_t;

    class pid_scoreboard;
        logic [31:0]   cfg_reg [REG_COUNT];
        longint        setpoint;
        longint        integ;
        longint        prev_err;
        drive_result_t expected_drive [$];
        int unsigned   mismatches;

        function new();
            foreach (cfg_reg[i])
            begin
                cfg_reg[i] = 32'h0;
            end
            cfg_reg[REG_PERIOD] = 32'd655;
            cfg_reg[REG_ILIM]   = 32'h7FFF_FFFF;
            setpoint   = 0;
            integ      = 0;
            prev_err   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            logic [31:0] v;
            v = value;
            if (idx == REG_ACCEL || idx == REG_PERIOD || idx == REG_ILIM)
            begin
                v[31] = 1'b0;
            end
            cfg_reg[idx] = v;
        endfunction

        function longint clip32(input longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // floor of the Q16.16 product, then saturate
        function longint mul_q16(input longint a, input longint b);
            longint p;
            p = a * b;
            return clip32(p >>> FRAC_W);
        endfunction

        function void note_sample(input logic action, input logic [31:0] meas_bits);
            longint        target;
            longint        meas;
            longint        step;
            longint        diff;
            longint        err;
            longint        lim;
            longint        deriv;
            longint        total;
            longint        half;
            drive_result_t r;
            if (action == ACT_CLEAR)
            begin
                integ = 0;
                return;
            end
            target = $signed(cfg_reg[REG_TARGET]);
            meas   = $signed(meas_bits);
            step   = cfg_reg[REG_ACCEL];
            if (step == 0)
            begin
                setpoint = target;
            end
            else
            begin
                diff = target - setpoint;
                if (diff > step)
                begin
                    diff = step;
                end
                else if (diff < -step)
                begin
                    diff = -step;
                end
                setpoint = clip32(setpoint + diff);
            end
            err   = clip32(setpoint - meas);
            integ = clip32(integ + mul_q16(err, longint'(cfg_reg[REG_PERIOD])));
            lim   = cfg_reg[REG_ILIM];
            // target and measurement both zero clear the integral
            if (cfg_reg[REG_TARGET] == 32'h0 && meas_bits == 32'h0)
            begin
                integ = 0;
            end
            else if (integ > lim)
            begin
                integ = lim;
            end
            else if (integ < -lim)
            begin
                integ = -lim;
            end
            deriv    = clip32(err - prev_err);
            prev_err = err;
            total = mul_q16($signed(cfg_reg[REG_KP]), err)
                  + mul_q16($signed(cfg_reg[REG_KI]), integ)
                  + mul_q16($signed(cfg_reg[REG_KFF]), setpoint)
                  + mul_q16($signed(cfg_reg[REG_KD]), deriv);
            half = longint'(1) << (FRAC_W - 1);
            r.saturated = 1'b0;
            if (total > half)
            begin
                total       = half;
                r.saturated = 1'b1;
            end
            else if (total < -half)
            begin
                total       = -half;
                r.saturated = 1'b1;
            end
            r.drive = total[DRIVE_W-1:0];
            expected_drive.push_back(r);
        endfunction

        function void check_drive(input logic [DRIVE_W-1:0] drive, input logic saturated);
            drive_result_t r;
            if (expected_drive.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result drive=%h saturated=%b", $time, drive,
                         saturated);
                return;
            end
            r = expected_drive.pop_front();
            if (drive !== r.drive)
            begin
                mismatches++;
                $display("%0t: drive expected %h actual %h", $time, r.drive, drive);
            end
            if (saturated !== r.saturated)
            begin
                mismatches++;
                $display("%0t: saturated expected %b actual %b", $time, r.saturated,
                         saturated);
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // [31:0] measured
    logic                s_tuser;   // [0] action
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;   // [16:0] drive, [23:17] zero
    logic                m_tuser;   // [0] saturated

    pid_scoreboard       sb;
    logic [31:0]         cfg_plan [REG_COUNT];
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         cycle_count;

    pid_ramped_setpoint_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_sample(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_drive(m_tdata[DRIVE_W-1:0], m_tuser);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_plan();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            write_reg(3'(i), cfg_plan[i]);
        end
    endtask

    task automatic send_item(input logic action, input logic [31:0] meas);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= meas;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // hold the sender until every result is back and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value(input int span_bits);
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return 32'($signed($urandom) >>> (32 - span_bits));
        endcase
    endfunction

    task automatic plan_random_config();
        cfg_plan[REG_TARGET] = pick_value(24);
        cfg_plan[REG_ACCEL]  = ($urandom_range(3) == 0) ? 32'h0
                             : (($urandom_range(7) == 0) ? $urandom
                             : $urandom_range(1, 32'h0010_0000));
        cfg_plan[REG_PERIOD] = ($urandom_range(7) == 0) ? $urandom
                             : $urandom_range(0, 32'h0002_0000);
        cfg_plan[REG_KP]     = pick_value(18);
        cfg_plan[REG_KI]     = pick_value(18);
        cfg_plan[REG_KD]     = pick_value(18);
        cfg_plan[REG_KFF]    = pick_value(14);
        case ($urandom_range(3))
            0: cfg_plan[REG_ILIM] = 32'h7FFF_FFFF;
            1: cfg_plan[REG_ILIM] = $urandom;
            default: cfg_plan[REG_ILIM] = $urandom_range(0, 32'h0040_0000);
        endcase
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [31:0] meas;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            send_item(ACT_CLEAR, $urandom);
        end
        else
        begin
            // track the target with noise most of the time
            if (pick < 60)
            begin
                meas = cfg_plan[REG_TARGET] + 32'($signed($urandom) >>> 14);
            end
            else if (pick < 75)
            begin
                meas = $urandom;
            end
            else if (pick < 85)
            begin
                meas = 32'h0;
            end
            else if (pick < 95)
            begin
                meas = ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            else
            begin
                meas = 32'($signed($urandom) >>> 20);
            end
            send_item(ACT_SAMPLE, meas);
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 9;
        recv_idle_pct = 72;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= 32'h0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'h0;
        s_tuser  <= ACT_SAMPLE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // proportional only: exact half-scale limits and the both-zero case
        cfg_plan[REG_TARGET] = 32'h0;
        cfg_plan[REG_ACCEL]  = 32'h0;
        cfg_plan[REG_PERIOD] = 32'd655;
        cfg_plan[REG_KP]     = 32'h0001_0000;
        cfg_plan[REG_KI]     = 32'h0;
        cfg_plan[REG_KD]     = 32'h0;
        cfg_plan[REG_KFF]    = 32'h0;
        cfg_plan[REG_ILIM]   = 32'h7FFF_FFFF;
        apply_plan();
        send_item(ACT_SAMPLE, 32'hFFFF_8000);
        send_item(ACT_SAMPLE, 32'h0000_8000);
        send_item(ACT_SAMPLE, 32'hFFFF_7FFF);
        send_item(ACT_SAMPLE, 32'h0000_8001);
        send_item(ACT_SAMPLE, 32'h0);
        send_item(ACT_SAMPLE, 32'h7FFF_FFFF);
        send_item(ACT_CLEAR, 32'hFFFF_FFFF);
        send_item(ACT_SAMPLE, 32'h8000_0000);
        drain();

        // ramped setpoint with all terms active and a tight integral clamp
        cfg_plan[REG_TARGET] = 32'h0040_0000;
        cfg_plan[REG_ACCEL]  = 32'h0010_0000;
        cfg_plan[REG_PERIOD] = 32'h0001_0000;
        cfg_plan[REG_KP]     = 32'h0000_0100;
        cfg_plan[REG_KI]     = 32'h0000_4000;
        cfg_plan[REG_KD]     = 32'hFFFF_E000;
        cfg_plan[REG_KFF]    = 32'h0000_0010;
        cfg_plan[REG_ILIM]   = 32'h0020_0000;
        apply_plan();
        repeat (5) send_item(ACT_SAMPLE, 32'h0);
        send_item(ACT_CLEAR, 32'h0);
        send_item(ACT_SAMPLE, 32'h0040_0000);
        send_item(ACT_SAMPLE, 32'h0040_0000);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF);
        drain();

        // every register at an extreme
        cfg_plan[REG_TARGET] = 32'h8000_0000;
        cfg_plan[REG_ACCEL]  = 32'h7FFF_FFFF;
        cfg_plan[REG_PERIOD] = 32'h7FFF_FFFF;
        cfg_plan[REG_KP]     = 32'h8000_0000;
        cfg_plan[REG_KI]     = 32'h7FFF_FFFF;
        cfg_plan[REG_KD]     = 32'h8000_0000;
        cfg_plan[REG_KFF]    = 32'h7FFF_FFFF;
        cfg_plan[REG_ILIM]   = 32'h0;
        apply_plan();
        send_item(ACT_SAMPLE, 32'h7FFF_FFFF);
        send_item(ACT_SAMPLE, 32'h8000_0000);
        send_item(ACT_SAMPLE, 32'h0);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int round = 0; round < 4; round++)
            begin
                if (round == 0 && phase == 0)
                begin
                    foreach (cfg_plan[i])
                    begin
                        cfg_plan[i] = 32'h7FFF_FFFF;
                    end
                end
                else if (round == 0 && phase == 1)
                begin
                    cfg_plan[REG_TARGET] = 32'h8000_0000;
                    cfg_plan[REG_ACCEL]  = 32'h0;
                    cfg_plan[REG_PERIOD] = 32'h0;
                    cfg_plan[REG_KP]     = 32'h8000_0000;
                    cfg_plan[REG_KI]     = 32'h8000_0000;
                    cfg_plan[REG_KD]     = 32'h8000_0000;
                    cfg_plan[REG_KFF]    = 32'h8000_0000;
                    cfg_plan[REG_ILIM]   = 32'h0;
                end
                else
                begin
                    plan_random_config();
                end
                apply_plan();
                repeat (70) send_random_item();
                drain();
            end
        end

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pidr_pkg.sv
rtl/pidr_regs.sv
rtl/pidr_sequencer.sv
rtl/pidr_datapath.sv
rtl/pid_ramped_setpoint_controller.sv
sim/testbench.sv
